// ===== hdl/wbps_pkg.sv =====
package wbps_pkg;

   // Fixed field and register widths
   localparam int PATTERN_BYTES = 32;
   localparam int PATTERN_WORDS = 4;
   localparam int WORD_W        = 64;
   localparam int CARE_W        = 32;
   localparam int LEN_W         = 6;
   localparam int ADDR_W        = 64;
   localparam int CSR_INDEX_W   = 3;

   // Defaults for the top-level parameters
   localparam int MAX_PATTERN_BYTES_DEFAULT = 32;
   localparam int COUNT_BITS_DEFAULT        = 32;

   // Register indexes of the configuration port
   typedef enum logic [CSR_INDEX_W-1:0] {
      CSR_PATTERN_WORD_0 = 3'd0,
      CSR_PATTERN_WORD_1 = 3'd1,
      CSR_PATTERN_WORD_2 = 3'd2,
      CSR_PATTERN_WORD_3 = 3'd3,
      CSR_CARE_MASK      = 3'd4,
      CSR_PATTERN_LENGTH = 3'd5,
      CSR_BASE_ADDRESS   = 3'd6
   } csr_index_type;

   // Input word: one byte of the scanned region
   typedef struct packed {
      logic [7:0] data_byte;
      logic       last_byte;
   } req_payload_type;

   // Result word
   typedef struct packed {
      logic              found;
      logic [ADDR_W-1:0] match_address;
   } rsp_payload_type;

   // Pattern as seen from the window: entry j lines up with window entry j
   typedef struct packed {
      logic [PATTERN_BYTES-1:0][7:0] win_pattern;
      logic [PATTERN_BYTES-1:0]      win_care;
      logic [LEN_W-1:0]              length;
      logic [ADDR_W-1:0]             base_address;
   } cfg_type;

endpackage

// ===== hdl/wbps_stream_if.sv =====
interface wbps_stream_if #(
   parameter type payload_type = logic
) ();

   logic        valid;
   logic        ready;
   payload_type data;

   modport source (output valid, output data, input ready);
   modport sink   (input valid, input data, output ready);

endinterface

// ===== hdl/wbps_csr.sv =====
module wbps_csr #(
   parameter int MAX_PATTERN_BYTES = wbps_pkg::MAX_PATTERN_BYTES_DEFAULT
) (
   input  logic                               clock,
   input  logic                               reset,
   input  logic                               csr_write_enable,
   input  logic [wbps_pkg::CSR_INDEX_W-1:0]   csr_index,
   input  logic [wbps_pkg::WORD_W-1:0]        csr_write_data,
   output wbps_pkg::cfg_type                  cfg
);

   localparam int LIMIT = (MAX_PATTERN_BYTES < wbps_pkg::PATTERN_BYTES) ?
                          MAX_PATTERN_BYTES : wbps_pkg::PATTERN_BYTES;

   logic [wbps_pkg::WORD_W-1:0] pattern_word_ff [wbps_pkg::PATTERN_WORDS];
   logic [wbps_pkg::CARE_W-1:0] care_mask_ff;
   logic [wbps_pkg::LEN_W-1:0]  pattern_length_ff;
   logic [wbps_pkg::ADDR_W-1:0] base_address_ff;

   logic [wbps_pkg::LEN_W-1:0]  active_len;
   logic [7:0]                  pattern_bytes [wbps_pkg::PATTERN_BYTES];

   // Take register writes; unknown indexes drop
   always_ff @(posedge clock) begin
      if (reset) begin
         for (int w = 0; w < wbps_pkg::PATTERN_WORDS; w++) begin
            pattern_word_ff[w] <= '0;
         end
         care_mask_ff      <= '0;
         pattern_length_ff <= wbps_pkg::LEN_W'(1);
         base_address_ff   <= '0;
      end else if (csr_write_enable) begin
         case (wbps_pkg::csr_index_type'(csr_index))
            wbps_pkg::CSR_PATTERN_WORD_0: pattern_word_ff[0] <= csr_write_data;
            wbps_pkg::CSR_PATTERN_WORD_1: pattern_word_ff[1] <= csr_write_data;
            wbps_pkg::CSR_PATTERN_WORD_2: pattern_word_ff[2] <= csr_write_data;
            wbps_pkg::CSR_PATTERN_WORD_3: pattern_word_ff[3] <= csr_write_data;
            wbps_pkg::CSR_CARE_MASK:
               care_mask_ff <= csr_write_data[wbps_pkg::CARE_W-1:0];
            wbps_pkg::CSR_PATTERN_LENGTH:
               pattern_length_ff <= csr_write_data[wbps_pkg::LEN_W-1:0];
            wbps_pkg::CSR_BASE_ADDRESS: base_address_ff <= csr_write_data;
            default: ;
         endcase
      end
   end

   // Clamp length: zero acts as one, long lengths stop at the window depth
   always_comb begin
      if (pattern_length_ff == '0) begin
         active_len = wbps_pkg::LEN_W'(1);
      end else if (pattern_length_ff > wbps_pkg::LEN_W'(LIMIT)) begin
         active_len = wbps_pkg::LEN_W'(LIMIT);
      end else begin
         active_len = pattern_length_ff;
      end
   end

   // Split the pattern words into bytes
   always_comb begin
      for (int i = 0; i < wbps_pkg::PATTERN_BYTES; i++) begin
         pattern_bytes[i] = pattern_word_ff[i >> 3][(i & 7) * 8 +: 8];
      end
   end

   // Reverse the active pattern so that its last byte meets the newest byte
   always_comb begin
      logic [wbps_pkg::LEN_W-1:0] idx;
      idx = '0;
      for (int j = 0; j < wbps_pkg::PATTERN_BYTES; j++) begin
         idx = active_len - wbps_pkg::LEN_W'(1) - wbps_pkg::LEN_W'(j);
         if (wbps_pkg::LEN_W'(j) < active_len) begin
            cfg.win_pattern[j] = pattern_bytes[idx[4:0]];
            cfg.win_care[j]    = care_mask_ff[idx[4:0]];
         end else begin
            cfg.win_pattern[j] = '0;
            cfg.win_care[j]    = 1'b0;
         end
      end
      cfg.length       = active_len;
      cfg.base_address = base_address_ff;
   end

endmodule

// ===== hdl/wbps_match.sv =====
module wbps_match #(
   parameter int MAX_PATTERN_BYTES = wbps_pkg::MAX_PATTERN_BYTES_DEFAULT,
   parameter int COUNT_BITS        = wbps_pkg::COUNT_BITS_DEFAULT
) (
   input  logic              clock,
   input  logic              reset,
   input  wbps_pkg::cfg_type cfg,
   wbps_stream_if.sink       req,
   wbps_stream_if.source     rsp
);

   localparam int WIN_DEPTH = (MAX_PATTERN_BYTES < wbps_pkg::PATTERN_BYTES) ?
                              MAX_PATTERN_BYTES : wbps_pkg::PATTERN_BYTES;

   // Input register
   logic                      in_valid_ff;
   logic [7:0]                in_byte_ff;
   logic                      in_last_ff;

   // Region state
   logic [7:0]                window_ff [WIN_DEPTH];
   logic [COUNT_BITS-1:0]     bytes_seen_ff;
   logic                      reported_ff;

   // Result register
   logic                      rsp_valid_ff;
   wbps_pkg::rsp_payload_type rsp_data_ff;

   logic                      advance;
   logic                      saturated;
   logic [COUNT_BITS-1:0]     bytes_seen_in;
   logic [7:0]                window_in [WIN_DEPTH];
   logic                      window_hit;
   logic                      long_enough;
   logic                      hit;
   logic                      emit;
   logic [COUNT_BITS-1:0]     offset;
   logic [wbps_pkg::ADDR_W-1:0] address;

   // Move the held word on when the result register has room
   assign advance   = in_valid_ff && (!rsp_valid_ff || rsp.ready);
   assign req.ready = !in_valid_ff || advance;

   // Count the byte unless saturated
   assign saturated     = &bytes_seen_ff;
   assign bytes_seen_in = saturated ? bytes_seen_ff : bytes_seen_ff + COUNT_BITS'(1);

   // Shift the held byte into the window
   always_comb begin
      window_in[0] = in_byte_ff;
      for (int j = 1; j < WIN_DEPTH; j++) begin
         window_in[j] = window_ff[j-1];
      end
   end

   // Compare all cared-for positions in parallel
   always_comb begin
      window_hit = 1'b1;
      for (int j = 0; j < WIN_DEPTH; j++) begin
         if (cfg.win_care[j] && (window_in[j] != cfg.win_pattern[j])) begin
            window_hit = 1'b0;
         end
      end
   end

   assign long_enough = bytes_seen_in >= COUNT_BITS'(cfg.length);
   assign hit  = !reported_ff && !saturated && long_enough && window_hit;
   assign emit = hit || (in_last_ff && !reported_ff);

   // Match start address
   assign offset  = bytes_seen_in - COUNT_BITS'(cfg.length);
   assign address = cfg.base_address + wbps_pkg::ADDR_W'(offset);

   // Hold the input word
   always_ff @(posedge clock) begin
      if (reset) begin
         in_valid_ff <= 1'b0;
      end else if (req.ready) begin
         in_valid_ff <= req.valid;
      end
      if (req.ready && req.valid) begin
         in_byte_ff <= req.data.data_byte;
         in_last_ff <= req.data.last_byte;
      end
   end

   // Update the region state; clear after the last byte
   always_ff @(posedge clock) begin
      if (reset) begin
         for (int j = 0; j < WIN_DEPTH; j++) begin
            window_ff[j] <= '0;
         end
         bytes_seen_ff <= '0;
         reported_ff   <= 1'b0;
      end else if (advance) begin
         if (in_last_ff) begin
            for (int j = 0; j < WIN_DEPTH; j++) begin
               window_ff[j] <= '0;
            end
            bytes_seen_ff <= '0;
            reported_ff   <= 1'b0;
         end else begin
            window_ff     <= window_in;
            bytes_seen_ff <= bytes_seen_in;
            reported_ff   <= reported_ff || hit;
         end
      end
   end

   // Load the result register, drop it once taken
   always_ff @(posedge clock) begin
      if (reset) begin
         rsp_valid_ff <= 1'b0;
      end else if (advance) begin
         rsp_valid_ff <= emit;
      end else if (rsp.ready) begin
         rsp_valid_ff <= 1'b0;
      end
      if (advance && emit) begin
         rsp_data_ff.found         <= hit;
         rsp_data_ff.match_address <= hit ? address : '0;
      end
   end

   assign rsp.valid = rsp_valid_ff;
   assign rsp.data  = rsp_data_ff;

endmodule

// ===== hdl/wildcard_byte_pattern_scanner_unit.sv =====
// Channel | Dir | Handshake     | Word
// req     | in  | valid / ready | data_byte[7:0], last_byte
// rsp     | out | valid / ready | found, match_address[63:0]
// csr     | in  | write enable  | csr_index[2:0], csr_write_data[63:0]
//
// One byte is taken every cycle unless a stalled result holds the input
// register. A taken byte sits in the input register, then the window compare
// and address add load the result register.
// Synchronous reset clears the valid bits, the window, the count and flags.
// A stalled result holds the input register; the held byte waits until the
// result register frees, so nothing is lost while rsp is stalled.
module wildcard_byte_pattern_scanner_unit #(
   parameter int MAX_PATTERN_BYTES = wbps_pkg::MAX_PATTERN_BYTES_DEFAULT,
   parameter int COUNT_BITS        = wbps_pkg::COUNT_BITS_DEFAULT
) (
   input  logic                             clock,
   input  logic                             reset,
   wbps_stream_if.sink                      req,
   wbps_stream_if.source                    rsp,
   input  logic                             csr_write_enable,
   input  logic [wbps_pkg::CSR_INDEX_W-1:0] csr_index,
   input  logic [wbps_pkg::WORD_W-1:0]      csr_write_data
);

   wbps_pkg::cfg_type cfg;

   wbps_csr #(
      .MAX_PATTERN_BYTES (MAX_PATTERN_BYTES)
   ) u_csr (
      .clock            (clock),
      .reset            (reset),
      .csr_write_enable (csr_write_enable),
      .csr_index        (csr_index),
      .csr_write_data   (csr_write_data),
      .cfg              (cfg)
   );

   wbps_match #(
      .MAX_PATTERN_BYTES (MAX_PATTERN_BYTES),
      .COUNT_BITS        (COUNT_BITS)
   ) u_match (
      .clock (clock),
      .reset (reset),
      .cfg   (cfg),
      .req   (req),
      .rsp   (rsp)
   );

endmodule
